// ----- sv/murmur3_32bit_hash_defines.svh -----
// Assertion macros shared by the hash block modules.
// Depends on the aclk and aresetn names used in every module of the block.
`ifndef MURMUR3_32BIT_HASH_DEFINES_SVH
`define MURMUR3_32BIT_HASH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MM3_ASSERT_NOW(label, cond, result, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (result)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MM3_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (result)) \
        else $error(msg);

`endif

// ----- sv/mm3_pkg.sv -----
// Shared types, constants and helpers for the MurmurHash3 x86_32 block.
// No dependencies.
package mm3_pkg;

    localparam logic [31:0] C1      = 32'hcc9e2d51;
    localparam logic [31:0] C2      = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] F1      = 32'h85ebca6b;
    localparam logic [31:0] F2      = 32'hc2b2ae35;

    localparam int QDEPTH  = 4;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [2:0] FULL_WORD = 3'd4;

    // One classified word between front and back.
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] word;    // bytes beyond counts 1 to 3 cleared
        logic [2:0]  count;   // effective byte count, 0 to 4
        logic        first;
        logic        last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

endpackage

// ----- sv/mm3_fifo.sv -----
// Short queue of classified words between front and back.
// Depends on mm3_pkg and murmur3_32bit_hash_defines.svh.
`include "murmur3_32bit_hash_defines.svh"

module mm3_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mm3_pkg::q_entry_t wdata,
    input  logic              pop,
    output mm3_pkg::q_entry_t head,
    output mm3_pkg::q_status_t stat
);

    mm3_pkg::q_entry_t                 mem [mm3_pkg::QDEPTH];
    logic [mm3_pkg::QADDR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mm3_pkg::QADDR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mm3_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);

    `MM3_ASSERT_NOW(a_no_overflow, push, !stat.full || pop, "push into full queue")
    `MM3_ASSERT_NOW(a_no_underflow, pop, !stat.empty, "pop from empty queue")
    `MM3_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH),
        "queue count beyond depth")

endmodule

// ----- sv/mm3_front.sv -----
// Input side: accepts words, tracks message start, classifies and masks.
// Depends on mm3_pkg and murmur3_32bit_hash_defines.svh.
`include "murmur3_32bit_hash_defines.svh"

module mm3_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [71:0]        s_tdata,
    input  logic               s_tlast,
    input  mm3_pkg::q_status_t q_stat,
    output logic               q_push,
    output mm3_pkg::q_entry_t  q_wdata
);

    logic        start_reg, start_next;
    logic [31:0] in_seed;
    logic [31:0] in_word;
    logic [2:0]  in_count;
    logic [2:0]  eff_count;
    logic [31:0] masked_word;

    assign in_seed  = s_tdata[31:0];
    assign in_word  = s_tdata[63:32];
    assign in_count = s_tdata[66:64];

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    // Non-final words are always full; counts above four saturate.
    always_comb begin
        if (!s_tlast || in_count > mm3_pkg::FULL_WORD) begin
            eff_count = mm3_pkg::FULL_WORD;
        end else begin
            eff_count = in_count;
        end
    end

    always_comb begin
        case (eff_count)
            3'd1: begin
                masked_word = in_word & 32'h0000_00ff;
            end
            3'd2: begin
                masked_word = in_word & 32'h0000_ffff;
            end
            3'd3: begin
                masked_word = in_word & 32'h00ff_ffff;
            end
            default: begin
                masked_word = in_word;
            end
        endcase
    end

    always_comb begin
        start_next = start_reg;
        if (q_push) begin
            start_next = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
        end else begin
            start_reg <= start_next;
        end
    end

    assign q_wdata.seed  = in_seed;
    assign q_wdata.word  = masked_word;
    assign q_wdata.count = eff_count;
    assign q_wdata.first = start_reg;
    assign q_wdata.last  = s_tlast;

    `MM3_ASSERT_NEXT(a_start_after_last, q_push && s_tlast, start_reg,
        "no message start after final word")
    `MM3_ASSERT_NEXT(a_mid_after_body, q_push && !s_tlast, !start_reg,
        "message start after body word")
    `MM3_ASSERT_NOW(a_body_full, q_push && !s_tlast, q_wdata.count == mm3_pkg::FULL_WORD,
        "body word not classified as full")

endmodule

// ----- sv/mm3_back.sv -----
// Execution side: key scramble, hash update, length fold and finalizer.
// Depends on mm3_pkg and murmur3_32bit_hash_defines.svh.
`include "murmur3_32bit_hash_defines.svh"

module mm3_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mm3_pkg::q_entry_t  q_head,
    input  mm3_pkg::q_status_t q_stat,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY2,
        S_MIX,
        S_FIN0,
        S_FIN1,
        S_FIN2
    } state_t;

    state_t      state_reg;
    logic [31:0] key_reg;
    logic [31:0] seed_reg;
    logic [2:0]  count_reg;
    logic        first_reg;
    logic        last_reg;
    logic [31:0] hash_reg;
    logic [31:0] len_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic [31:0] key_mul1;
    logic [31:0] key_rot;
    logic [31:0] key_mul2;
    logic [31:0] hash_base;
    logic [31:0] len_base;
    logic [31:0] hash_xk;
    logic [31:0] hash_rot;
    logic [31:0] hash_mix;
    logic [31:0] len_mix;
    logic [31:0] fold;
    logic [31:0] fin0_in;
    logic [31:0] fin0_mul;
    logic [31:0] fin1_in;
    logic [31:0] fin1_mul;
    logic        out_free;

    assign q_pop    = (state_reg == S_IDLE) && !q_stat.empty;
    assign out_free = !out_valid_reg || m_tready;

    assign key_mul1 = q_head.word * mm3_pkg::C1;
    assign key_rot  = mm3_pkg::rotl15(key_reg);
    assign key_mul2 = key_rot * mm3_pkg::C2;

    // The first word of a message starts from the seed and a zero length.
    assign hash_base = first_reg ? seed_reg : hash_reg;
    assign len_base  = first_reg ? 32'd0 : len_reg;
    assign hash_xk   = hash_base ^ key_reg;
    assign hash_rot  = mm3_pkg::rotl13(hash_xk);
    assign len_mix   = len_base + {29'd0, count_reg};

    always_comb begin
        if (count_reg == mm3_pkg::FULL_WORD) begin
            hash_mix = {hash_rot[29:0], 2'b00} + hash_rot + mm3_pkg::MIX_ADD;
        end else if (count_reg != 3'd0) begin
            hash_mix = hash_xk;
        end else begin
            hash_mix = hash_base;
        end
    end

    assign fold     = hash_reg ^ len_reg;
    assign fin0_in  = fold ^ {16'd0, fold[31:16]};
    assign fin0_mul = fin0_in * mm3_pkg::F1;
    assign fin1_in  = hash_reg ^ {13'd0, hash_reg[31:13]};
    assign fin1_mul = fin1_in * mm3_pkg::F2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // Drop the result after its transfer unless a new one loads now.
            if (out_valid_reg && m_tready && state_reg != S_FIN2) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        key_reg   <= key_mul1;
                        seed_reg  <= q_head.seed;
                        count_reg <= q_head.count;
                        first_reg <= q_head.first;
                        last_reg  <= q_head.last;
                        state_reg <= S_KEY2;
                    end
                end
                S_KEY2: begin
                    key_reg   <= key_mul2;
                    state_reg <= S_MIX;
                end
                S_MIX: begin
                    hash_reg  <= hash_mix;
                    len_reg   <= len_mix;
                    state_reg <= last_reg ? S_FIN0 : S_IDLE;
                end
                S_FIN0: begin
                    hash_reg  <= fin0_mul;
                    state_reg <= S_FIN1;
                end
                S_FIN1: begin
                    hash_reg  <= fin1_mul;
                    state_reg <= S_FIN2;
                end
                S_FIN2: begin
                    if (out_free) begin
                        out_data_reg  <= hash_reg ^ {16'd0, hash_reg[31:16]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `MM3_ASSERT_NOW(a_pop_idle, q_pop, state_reg == S_IDLE, "queue pop while busy")
    `MM3_ASSERT_NOW(a_result_from_fin, $rose(out_valid_reg), $past(state_reg) == S_FIN2,
        "result raised outside final stage")
    `MM3_ASSERT_NEXT(a_body_returns, state_reg == S_MIX && !last_reg, state_reg == S_IDLE,
        "body word did not return to idle")

endmodule

// ----- sv/murmur3_32bit_hash.sv -----
// Top level of the MurmurHash3 x86_32 stream hasher.
// Depends on mm3_pkg, mm3_front, mm3_fifo and mm3_back.
//
//  channel   dir  data bits (low first)                          marker
//  s_        in   seed[31:0] data_word[63:32] byte_count[66:64]  tlast = last_word
//  m_        out  hash_value[31:0]                               none
//
// A body word passes through the execution sequencer's pop, second key
// multiply and hash update states; a final word adds three finalizer steps.
// The sequencer's one-word-at-a-time loop sets the sustained rate.
// Reset is synchronous, active low; the next word after reset starts a message.
// A stalled result holds in its register; the queue keeps taking words until full.
module murmur3_32bit_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // seed, data_word, byte_count, zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hash_value
);

    mm3_pkg::q_entry_t  q_wdata;
    mm3_pkg::q_entry_t  q_head;
    mm3_pkg::q_status_t q_stat;
    logic               q_push;
    logic               q_pop;

    // Accept and classify each transfer.
    mm3_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Hold classified words until the sequencer is free.
    mm3_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    // Mix, finalize and drive the result register.
    mm3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
